// File: rtl/rvr_pkg.sv
// rvr_pkg: shared constants and helpers for the rodrigues rotation pipeline
package rvr_pkg;

    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 31;
    localparam int CORDIC_STEPS = 30;
    localparam int FRONT_STAGES = 6;
    localparam int TAIL_STAGES  = 8;
    localparam int PIPE_LAT     = FRONT_STAGES + SQRT_STEPS + 1 + DIV_STEPS + TAIL_STAGES;
    localparam int MAT_W        = 34;

    localparam logic signed [31:0] ANGLE_LIMIT = 32'sd1686629713;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
    };

    // round a q30 product back to q30, ties toward plus infinity
    function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
        return (v + 64'sd536870912) >>> 30;
    endfunction

endpackage

// File: rtl/rodrigues_vector_rotation.sv
// rodrigues_vector_rotation: pipelined rotation of a point about an arbitrary axis
// A new item is taken on every clock where start is high; busy is always low since the
// pipeline never stalls. Results appear on done in the order that the items were taken,
// one result per clock at full rate. The latency is set by the chain of a 32-stage square
// root of the axis length and a 31-stage divider that forms the unit axis, with the 30-step
// sine/cosine running alongside. An all-zero axis returns the point unchanged with axis_zero
// set; results saturate to the coordinate range.
module rodrigues_vector_rotation #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic signed [COORD_WIDTH-1:0] axis_x,
    input  logic signed [COORD_WIDTH-1:0] axis_y,
    input  logic signed [COORD_WIDTH-1:0] axis_z,
    input  logic signed [31:0]            turn_angle,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] rotated_x,
    output logic signed [COORD_WIDTH-1:0] rotated_y,
    output logic signed [COORD_WIDTH-1:0] rotated_z,
    output logic                          axis_zero
);

    localparam int CW   = COORD_WIDTH;
    localparam int KW   = $clog2(CW);
    localparam int PX   = (CW > 25) ? CW : 25;
    localparam int HW   = PX - 24;
    localparam int MW   = rvr_pkg::MAT_W;
    localparam int PHW  = MW + HW;
    localparam int PLW  = MW + 25;
    localparam int SHW  = PHW + 2;
    localparam int SLW  = PLW + 2;
    localparam int XW   = SHW + 1;
    localparam int RW   = XW - 6;
    localparam int LAT  = rvr_pkg::PIPE_LAT;
    localparam int SQN  = rvr_pkg::SQRT_STEPS;
    localparam int DVN  = rvr_pkg::DIV_STEPS;
    localparam int CRN  = rvr_pkg::CORDIC_STEPS;
    localparam int DV_LAST = rvr_pkg::FRONT_STAGES + SQN + 1 + DVN;

    typedef struct packed {
        logic               zero;
        logic [2:0]         neg;
        logic [2:0][CW-1:0] pt;
    } carry_t;

    logic              accept;
    logic [LAT-1:0]    vld_reg;
    carry_t            crr_next;
    carry_t            crr_reg [1:LAT-1];

    logic [2:0][CW-1:0] pin;
    logic [2:0][CW-1:0] ain;

    // front end
    logic [2:0][CW-1:0]  mag1_next, mag1_reg, mag2_reg, mag3_reg;
    logic signed [31:0]  ang1_next, ang1_reg;
    logic [CW-1:0]       mx2_next, mx2_reg;
    logic signed [33:0]  z2_next;
    logic                tn2_next;
    logic signed [33:0]  zf_reg [2:6];
    logic                tf_reg [2:6];
    logic [KW-1:0]       lead;
    logic                shr3_next, shr3_reg;
    logic [5:0]          sha3_next, sha3_reg;
    logic [2:0][30:0]    nrm4_next, nrm4_reg, nrm5_reg, nrm6_reg;
    logic [2:0][61:0]    sq5_next, sq5_reg;
    logic [63:0]         sum6_reg;

    // square root and cordic
    logic [63:0]         sn_reg [0:SQN-1];
    logic [63:0]         sr_reg [0:SQN-1];
    logic [2:0][30:0]    nrm_reg [0:SQN-1];
    logic signed [33:0]  cx_reg [0:SQN-1];
    logic signed [33:0]  cy_reg [0:SQN-1];
    logic signed [33:0]  cz_reg [0:SQN-1];
    logic                cn_reg [0:SQN-1];

    // dividers
    logic [2:0][61:0]    drem_reg [0:DVN];
    logic [2:0][30:0]    dq_reg [0:DVN];
    logic [31:0]         dlen_reg [0:DVN];
    logic signed [31:0]  dc_reg [0:DVN];
    logic signed [31:0]  ds_reg [0:DVN];

    // matrix and product tail
    logic signed [31:0]    u_next [3];
    logic signed [31:0]    u_reg [3];
    logic signed [31:0]    c71_reg, s71_reg, c72_reg, c73_reg;
    logic signed [31:0]    uu_next [3][3];
    logic signed [31:0]    uu_reg [3][3];
    logic signed [31:0]    su_next [3];
    logic signed [31:0]    su_reg [3];
    logic signed [31:0]    su73_reg [3];
    logic signed [32:0]    omc_reg;
    logic signed [32:0]    pm_next [3][3];
    logic signed [32:0]    pm_reg [3][3];
    logic signed [MW-1:0]  m_next [3][3];
    logic signed [MW-1:0]  m_reg [3][3];
    logic signed [PHW-1:0] ph_next [3][3];
    logic signed [PHW-1:0] ph_reg [3][3];
    logic signed [PLW-1:0] pl_next [3][3];
    logic signed [PLW-1:0] pl_reg [3][3];
    logic signed [SHW-1:0] sh_next [3];
    logic signed [SHW-1:0] sh_reg [3];
    logic signed [SLW-1:0] sl_next [3];
    logic signed [SLW-1:0] sl_reg [3];
    logic signed [XW-1:0]  xq_next [3];
    logic signed [XW-1:0]  xq_reg [3];
    logic [2:0][CW-1:0]    rot_next, rot_reg;
    logic                  axis_zero_reg;

    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign pin    = {point_z, point_y, point_x};
    assign ain    = {axis_z, axis_y, axis_x};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], accept};
        end
    end

    assign crr_next.zero = ~|ain;
    assign crr_next.pt   = pin;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            crr_next.neg[i] = ain[i][CW-1];
            mag1_next[i]    = ain[i][CW-1] ? (~ain[i] + 1'b1) : ain[i];
        end
    end

    always_ff @(posedge clk)
    begin
        crr_reg[1] <= crr_next;
        for (int s = 2; s < LAT; s++)
        begin
            crr_reg[s] <= crr_reg[s-1];
        end
    end

    // stage 1: magnitudes and angle clamp
    always_comb
    begin
        ang1_next = turn_angle;
        if (turn_angle > rvr_pkg::ANGLE_LIMIT)
        begin
            ang1_next = rvr_pkg::ANGLE_LIMIT;
        end
        else if (turn_angle < -rvr_pkg::ANGLE_LIMIT)
        begin
            ang1_next = -rvr_pkg::ANGLE_LIMIT;
        end
    end

    // stage 2: largest magnitude and angle folded into plus or minus pi/2
    always_comb
    begin
        logic signed [33:0] z2;
        z2       = $signed({ang1_reg[31], ang1_reg, 1'b0});
        mx2_next = (mag1_reg[0] > mag1_reg[1]) ? mag1_reg[0] : mag1_reg[1];
        if (mag1_reg[2] > mx2_next)
        begin
            mx2_next = mag1_reg[2];
        end
        z2_next  = z2;
        tn2_next = 1'b0;
        if (z2 > rvr_pkg::HALF_PI_Q30)
        begin
            z2_next  = z2 - rvr_pkg::PI_Q30;
            tn2_next = 1'b1;
        end
        else if (z2 < -rvr_pkg::HALF_PI_Q30)
        begin
            z2_next  = z2 + rvr_pkg::PI_Q30;
            tn2_next = 1'b1;
        end
    end

    // stage 3: leading one of the largest magnitude
    always_comb
    begin
        lead = '0;
        for (int b = 0; b < CW; b++)
        begin
            if (mx2_reg[b])
            begin
                lead = KW'(b);
            end
        end
        shr3_next = (int'(lead) > 30);
        sha3_next = shr3_next ? 6'(int'(lead) - 30) : 6'(30 - int'(lead));
    end

    // stage 4: normalize so the largest magnitude sits in [2^30, 2^31)
    always_comb
    begin
        logic [CW+30:0] w;
        for (int i = 0; i < 3; i++)
        begin
            w = {31'b0, mag3_reg[i]};
            w = shr3_reg ? (w >> sha3_reg) : (w << sha3_reg);
            nrm4_next[i] = w[30:0];
        end
    end

    // stage 5: squares
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq5_next[i] = nrm4_reg[i] * nrm4_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        mag1_reg <= mag1_next;
        ang1_reg <= ang1_next;
        mag2_reg <= mag1_reg;
        mx2_reg  <= mx2_next;
        zf_reg[2] <= z2_next;
        tf_reg[2] <= tn2_next;
        for (int s = 3; s <= 6; s++)
        begin
            zf_reg[s] <= zf_reg[s-1];
            tf_reg[s] <= tf_reg[s-1];
        end
        mag3_reg <= mag2_reg;
        shr3_reg <= shr3_next;
        sha3_reg <= sha3_next;
        nrm4_reg <= nrm4_next;
        sq5_reg  <= sq5_next;
        nrm5_reg <= nrm4_reg;
        sum6_reg <= 64'(sq5_reg[0]) + 64'(sq5_reg[1]) + 64'(sq5_reg[2]);
        nrm6_reg <= nrm5_reg;
    end

    // square root one bit a stage, cordic one step a stage alongside
    for (genvar k = 0; k < SQN; k++) begin : g_sqrt
        localparam logic [63:0] BITV = 64'd1 << (62 - 2*k);
        logic [63:0]        n_in;
        logic [63:0]        r_in;
        logic [63:0]        trial;
        logic [2:0][30:0]   nrm_in;
        logic signed [33:0] x_in;
        logic signed [33:0] y_in;
        logic signed [33:0] z_in;
        logic               tn_in;

        if (k == 0) begin : g_first
            assign n_in   = sum6_reg;
            assign r_in   = '0;
            assign nrm_in = nrm6_reg;
            assign x_in   = rvr_pkg::CORDIC_GAIN;
            assign y_in   = '0;
            assign z_in   = zf_reg[6];
            assign tn_in  = tf_reg[6];
        end
        else begin : g_next
            assign n_in   = sn_reg[k-1];
            assign r_in   = sr_reg[k-1];
            assign nrm_in = nrm_reg[k-1];
            assign x_in   = cx_reg[k-1];
            assign y_in   = cy_reg[k-1];
            assign z_in   = cz_reg[k-1];
            assign tn_in  = cn_reg[k-1];
        end

        assign trial = r_in + BITV;

        always_ff @(posedge clk)
        begin
            if (n_in >= trial)
            begin
                sn_reg[k] <= n_in - trial;
                sr_reg[k] <= (r_in >> 1) + BITV;
            end
            else
            begin
                sn_reg[k] <= n_in;
                sr_reg[k] <= r_in >> 1;
            end
            nrm_reg[k] <= nrm_in;
            cn_reg[k]  <= tn_in;
        end

        if (k < CRN) begin : g_rot
            always_ff @(posedge clk)
            begin
                if (z_in >= 0)
                begin
                    cx_reg[k] <= x_in - (y_in >>> k);
                    cy_reg[k] <= y_in + (x_in >>> k);
                    cz_reg[k] <= z_in - $signed({2'b0, rvr_pkg::ATAN_TAB[k]});
                end
                else
                begin
                    cx_reg[k] <= x_in + (y_in >>> k);
                    cy_reg[k] <= y_in - (x_in >>> k);
                    cz_reg[k] <= z_in + $signed({2'b0, rvr_pkg::ATAN_TAB[k]});
                end
            end
        end
        else if (k == CRN) begin : g_fin
            // undo the fold, then clamp to the unit range
            always_ff @(posedge clk)
            begin
                logic signed [33:0] xf;
                logic signed [33:0] yf;
                xf = tn_in ? -x_in : x_in;
                yf = tn_in ? -y_in : y_in;
                if (xf > rvr_pkg::Q30_ONE)
                begin
                    xf = rvr_pkg::Q30_ONE;
                end
                else if (xf < -rvr_pkg::Q30_ONE)
                begin
                    xf = -rvr_pkg::Q30_ONE;
                end
                if (yf > rvr_pkg::Q30_ONE)
                begin
                    yf = rvr_pkg::Q30_ONE;
                end
                else if (yf < -rvr_pkg::Q30_ONE)
                begin
                    yf = -rvr_pkg::Q30_ONE;
                end
                cx_reg[k] <= xf;
                cy_reg[k] <= yf;
                cz_reg[k] <= z_in;
            end
        end
        else begin : g_hold
            always_ff @(posedge clk)
            begin
                cx_reg[k] <= x_in;
                cy_reg[k] <= y_in;
                cz_reg[k] <= z_in;
            end
        end
    end

    // divider setup: rounded dividend
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            drem_reg[0][i] <= {nrm_reg[SQN-1][i], 30'b0} + {31'b0, sr_reg[SQN-1][31:1]};
        end
        dq_reg[0]   <= '0;
        dlen_reg[0] <= sr_reg[SQN-1][31:0];
        dc_reg[0]   <= 32'(cx_reg[SQN-1]);
        ds_reg[0]   <= 32'(cy_reg[SQN-1]);
    end

    // restoring dividers, one quotient bit a stage
    for (genvar j = 1; j <= DVN; j++) begin : g_div
        localparam int B = DVN - j;
        logic [61:0] dv;

        assign dv = {30'b0, dlen_reg[j-1]} << B;

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (drem_reg[j-1][i] >= dv)
                begin
                    drem_reg[j][i] <= drem_reg[j-1][i] - dv;
                    dq_reg[j][i]   <= dq_reg[j-1][i] | (31'd1 << B);
                end
                else
                begin
                    drem_reg[j][i] <= drem_reg[j-1][i];
                    dq_reg[j][i]   <= dq_reg[j-1][i];
                end
            end
            dlen_reg[j] <= dlen_reg[j-1];
            dc_reg[j]   <= dc_reg[j-1];
            ds_reg[j]   <= ds_reg[j-1];
        end
    end

    // signed unit axis
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_next[i] = crr_reg[DV_LAST].neg[i] ? -$signed({1'b0, dq_reg[DVN][i]})
                                                :  $signed({1'b0, dq_reg[DVN][i]});
        end
    end

    // outer products and sine terms
    always_comb
    begin
        logic signed [63:0] pr;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pr = u_reg[i] * u_reg[j];
                uu_next[i][j] = 32'(rvr_pkg::rnd30(pr));
            end
            pr = s71_reg * u_reg[i];
            su_next[i] = 32'(rvr_pkg::rnd30(pr));
        end
    end

    // scale by one minus cosine
    always_comb
    begin
        logic signed [63:0] pr;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pr = omc_reg * uu_reg[i][j];
                pm_next[i][j] = 33'(rvr_pkg::rnd30(pr));
            end
        end
    end

    // rotation matrix
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                m_next[i][j] = MW'(pm_reg[i][j]);
                if (i == j)
                begin
                    m_next[i][j] = m_next[i][j] + MW'(c73_reg);
                end
                else if (((j - i + 3) % 3) == 1)
                begin
                    m_next[i][j] = m_next[i][j] - MW'(su73_reg[3 - i - j]);
                end
                else
                begin
                    m_next[i][j] = m_next[i][j] + MW'(su73_reg[3 - i - j]);
                end
            end
        end
    end

    // matrix times point, split into high and low point pieces
    always_comb
    begin
        logic signed [PX-1:0] pe;
        for (int j = 0; j < 3; j++)
        begin
            pe = PX'($signed(crr_reg[LAT-4].pt[j]));
            for (int i = 0; i < 3; i++)
            begin
                ph_next[i][j] = m_reg[i][j] * $signed(pe[PX-1:24]);
                pl_next[i][j] = m_reg[i][j] * $signed({1'b0, pe[23:0]});
            end
        end
    end

    always_comb
    begin
        logic signed [SLW-1:0] slr;
        logic signed [RW-1:0]  r;
        for (int i = 0; i < 3; i++)
        begin
            sh_next[i] = SHW'(ph_reg[i][0]) + SHW'(ph_reg[i][1]) + SHW'(ph_reg[i][2]);
            sl_next[i] = SLW'(pl_reg[i][0]) + SLW'(pl_reg[i][1]) + SLW'(pl_reg[i][2]);
            slr        = (sl_reg[i] + SLW'(64'sd536870912)) >>> 24;
            xq_next[i] = XW'(sh_reg[i]) + XW'(slr);
            r          = RW'(xq_reg[i] >>> 6);
            if ((&r[RW-1:CW-1]) || !(|r[RW-1:CW-1]))
            begin
                rot_next[i] = r[CW-1:0];
            end
            else
            begin
                rot_next[i] = r[RW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            end
            if (crr_reg[LAT-1].zero)
            begin
                rot_next[i] = crr_reg[LAT-1].pt[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg   <= u_next;
        c71_reg <= dc_reg[DVN];
        s71_reg <= ds_reg[DVN];
        uu_reg  <= uu_next;
        su_reg  <= su_next;
        omc_reg <= 33'sd1073741824 - 33'(c71_reg);
        c72_reg <= c71_reg;
        pm_reg  <= pm_next;
        su73_reg <= su_reg;
        c73_reg <= c72_reg;
        m_reg   <= m_next;
        ph_reg  <= ph_next;
        pl_reg  <= pl_next;
        sh_reg  <= sh_next;
        sl_reg  <= sl_next;
        xq_reg  <= xq_next;
        rot_reg <= rot_next;
        axis_zero_reg <= crr_reg[LAT-1].zero;
    end

    assign done      = vld_reg[LAT-1];
    assign rotated_x = rot_reg[0];
    assign rotated_y = rot_reg[1];
    assign rotated_z = rot_reg[2];
    assign axis_zero = axis_zero_reg;

endmodule

// File: rtl/rvr_checker.sv
// rvr_checker: port-level timing and pass-through checks, bound to the top level
module rvr_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic signed [COORD_WIDTH-1:0] point_x,
    input logic signed [COORD_WIDTH-1:0] point_y,
    input logic signed [COORD_WIDTH-1:0] point_z,
    input logic signed [COORD_WIDTH-1:0] axis_x,
    input logic signed [COORD_WIDTH-1:0] axis_y,
    input logic signed [COORD_WIDTH-1:0] axis_z,
    input logic signed [31:0]            turn_angle,
    input logic                          done,
    input logic signed [COORD_WIDTH-1:0] rotated_x,
    input logic signed [COORD_WIDTH-1:0] rotated_y,
    input logic signed [COORD_WIDTH-1:0] rotated_z,
    input logic                          axis_zero
);

    localparam int LAT = rvr_pkg::PIPE_LAT;

    a_item_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("item taken without a result after the pipeline latency");

    a_zero_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && axis_x == 0 && axis_y == 0 && axis_z == 0) |-> ##LAT
        (axis_zero && rotated_x == $past(point_x, LAT) && rotated_y == $past(point_y, LAT)
         && rotated_z == $past(point_z, LAT)))
        else $error("zero axis item did not pass through");

    a_nonzero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (axis_x != 0 || axis_y != 0 || axis_z != 0)) |-> ##LAT !axis_zero)
        else $error("axis_zero set for a nonzero axis");

endmodule

bind rodrigues_vector_rotation rvr_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rvr_checker (.*);

// File: verif/rodrigues_vector_rotation_test.sv
// rodrigues_vector_rotation_test: self-checking testbench for the rodrigues rotation pipeline
module rodrigues_vector_rotation_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 450;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 zero;
    } rotated_t;

    typedef struct {
        logic signed [CW-1:0] px, py, pz;
        logic signed [CW-1:0] ax, ay, az;
        logic signed [31:0]   ang;
    } item_t;

    localparam longint ONE30 = 64'sd1073741824;
    localparam longint UNIT_GAIN = 64'sd652032874;
    localparam longint HALF_PI = 64'sd1686629713;
    localparam longint FULL_PI = 64'sd3373259426;

    function automatic longint round30(input longint v);
        return (v + 64'sd536870912) >>> 30;
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(input longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[CW-1:0];
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint row_dot(input longint m0, input longint m1, input longint m2,
                                       input longint p0, input longint p1, input longint p2);
        longint mv[3];
        longint pv[3];
        longint sh, sl, hi, lo;
        mv[0] = m0; mv[1] = m1; mv[2] = m2;
        pv[0] = p0; pv[1] = p1; pv[2] = p2;
        sh = 0;
        sl = 0;
        for (int j = 0; j < 3; j++) begin
            hi = pv[j] >>> 24;
            lo = pv[j] - hi * (64'sd1 <<< 24);
            sh += mv[j] * hi;
            sl += mv[j] * lo;
        end
        return (sh + ((sl + 64'sd536870912) >>> 24)) >>> 6;
    endfunction

    function automatic rotated_t rotate_point(input item_t it);
        rotated_t r;
        longint p[3], a[3], u[3], m[9], su[3];
        longint unsigned mag[3];
        longint unsigned mx, sum, len, q;
        longint ang, z, x, y, t, xs, ys, c, s, omc, uu;
        logic neg;
        p[0] = it.px; p[1] = it.py; p[2] = it.pz;
        a[0] = it.ax; a[1] = it.ay; a[2] = it.az;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (a[i] < 0) ? longint'(-a[i]) : longint'(a[i]);
            if (mag[i] > mx) mx = mag[i];
        end
        if (mx == 0) begin
            r.x = it.px; r.y = it.py; r.z = it.pz; r.zero = 1'b1;
            return r;
        end
        while (mx >= (64'd1 << 31)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        while (mx < (64'd1 << 30)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 30) + (len >> 1)) / len;
            u[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
        end
        ang = it.ang;
        if (ang > HALF_PI) ang = HALF_PI;
        if (ang < -HALF_PI) ang = -HALF_PI;
        z = ang * 2;
        x = UNIT_GAIN;
        y = 0;
        neg = 1'b0;
        if (z > HALF_PI) begin z -= FULL_PI; neg = 1'b1; end
        else if (z < -HALF_PI) begin z += FULL_PI; neg = 1'b1; end
        for (int i = 0; i < 30; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                t = x - ys; y = y + xs; z -= longint'(rvr_pkg::ATAN_TAB[i]);
            end
            else begin
                t = x + ys; y = y - xs; z += longint'(rvr_pkg::ATAN_TAB[i]);
            end
            x = t;
        end
        if (neg) begin x = -x; y = -y; end
        if (x > ONE30) x = ONE30;
        if (x < -ONE30) x = -ONE30;
        if (y > ONE30) y = ONE30;
        if (y < -ONE30) y = -ONE30;
        c = x;
        s = y;
        omc = ONE30 - c;
        for (int i = 0; i < 3; i++) begin
            su[i] = round30(s * u[i]);
            for (int j = 0; j < 3; j++) begin
                uu = round30(u[i] * u[j]);
                m[i*3+j] = round30(omc * uu) + ((i == j) ? c : 0);
            end
        end
        m[1] -= su[2]; m[2] += su[1];
        m[3] += su[2]; m[5] -= su[0];
        m[6] -= su[1]; m[7] += su[0];
        r.x = clamp_coord(row_dot(m[0], m[1], m[2], p[0], p[1], p[2]));
        r.y = clamp_coord(row_dot(m[3], m[4], m[5], p[0], p[1], p[2]));
        r.z = clamp_coord(row_dot(m[6], m[7], m[8], p[0], p[1], p[2]));
        r.zero = 1'b0;
        return r;
    endfunction

    class rotation_scoreboard;
        rotated_t pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        task report(input string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task note_item(input item_t it);
            pending.push_back(rotate_point(it));
        endtask

        task check_result(input rotated_t got);
            rotated_t want;
            if (pending.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x)
                report($sformatf("rotated_x got %0d want %0d", got.x, want.x));
            if (got.y !== want.y)
                report($sformatf("rotated_y got %0d want %0d", got.y, want.y));
            if (got.z !== want.z)
                report($sformatf("rotated_z got %0d want %0d", got.z, want.z));
            if (got.zero !== want.zero)
                report($sformatf("axis_zero got %0b want %0b", got.zero, want.zero));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [CW-1:0] point_x = '0, point_y = '0, point_z = '0;
    logic signed [CW-1:0] axis_x = '0, axis_y = '0, axis_z = '0;
    logic signed [31:0] turn_angle = '0;
    logic done;
    logic signed [CW-1:0] rotated_x, rotated_y, rotated_z;
    logic axis_zero;
    int cycles = 0;

    rotation_scoreboard board = new();

    rodrigues_vector_rotation #(.COORD_WIDTH(CW)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
        .turn_angle(turn_angle), .done(done),
        .rotated_x(rotated_x), .rotated_y(rotated_y), .rotated_z(rotated_z),
        .axis_zero(axis_zero)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        item_t it;
        rotated_t got;
        cycles <= cycles + 1;
        if (rst_n && start && !busy) begin
            it.px = point_x; it.py = point_y; it.pz = point_z;
            it.ax = axis_x; it.ay = axis_y; it.az = axis_z;
            it.ang = turn_angle;
            board.note_item(it);
        end
        if (rst_n && done) begin
            got.x = rotated_x; got.y = rotated_y; got.z = rotated_z; got.zero = axis_zero;
            board.check_result(got);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("rodrigues_vector_rotation_test: FAIL");
            $finish;
        end
    end

    // one item per call; start stays high across back-to-back items
    task drive_item(input item_t it, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        point_x <= it.px; point_y <= it.py; point_z <= it.pz;
        axis_x <= it.ax; axis_y <= it.ay; axis_z <= it.az;
        turn_angle <= it.ang;
        do @(negedge clk); while (busy);
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 255)) - 128;
            2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            4: return 0;
            default: return $signed($urandom_range(0, 32'h3fffff)) - 32'sh200000;
        endcase
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.px = pick_coord(); it.py = pick_coord(); it.pz = pick_coord();
        it.ax = pick_coord(); it.ay = pick_coord(); it.az = pick_coord();
        if ($urandom_range(0, 15) == 0) begin
            it.ax = 0; it.ay = 0; it.az = 0;
        end
        case ($urandom_range(0, 5))
            0: it.ang = $urandom;
            1: it.ang = $urandom_range(0, 1) ? rvr_pkg::ANGLE_LIMIT : -rvr_pkg::ANGLE_LIMIT;
            default: it.ang = $signed($urandom_range(0, 2 * 1686629713)) - 32'sd1686629713;
        endcase
        return it;
    endfunction

    function automatic item_t make_item(input longint px, input longint py, input longint pz,
                                        input longint ax, input longint ay, input longint az,
                                        input longint ang);
        item_t it;
        it.px = px; it.py = py; it.pz = pz;
        it.ax = ax; it.ay = ay; it.az = az;
        it.ang = ang;
        return it;
    endfunction

    initial
    begin
        item_t list[$];
        int settle;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // zero axis, extreme points, angle limits, shift paths and saturation
        list.push_back(make_item(65536, -65536, 12345, 0, 0, 0, 536870912));
        list.push_back(make_item(32'h7fffffff, -32'sh80000000, 0, 0, 0, 0, 0));
        list.push_back(make_item(65536, 0, 0, 0, 0, 65536, 843314856));
        list.push_back(make_item(65536, 0, 0, 0, 0, 65536, 1686629713));
        list.push_back(make_item(65536, 0, 0, 0, 0, 65536, -1686629713));
        list.push_back(make_item(65536, 0, 0, 0, 0, 65536, 32'sh7fffffff));
        list.push_back(make_item(65536, 0, 0, 0, 0, 65536, -32'sh80000000));
        list.push_back(make_item(0, 65536, 0, 1, 0, 0, 843314857));
        list.push_back(make_item(0, 0, 65536, -32'sh80000000, 0, 0, 843314856));
        list.push_back(make_item(0, 0, 65536, -32'sh80000000, -32'sh80000000,
                                 -32'sh80000000, 1000000000));
        list.push_back(make_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 65536, 0, 0,
                                 843314856));
        list.push_back(make_item(-32'sh80000000, -32'sh80000000, -32'sh80000000,
                                 1, -1, 1, -843314856));
        list.push_back(make_item(32'h7fffffff, -32'sh80000000, 32'h7fffffff,
                                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1686629713));
        list.push_back(make_item(1, -1, 1, 3, 4, 12, 0));
        list.push_back(make_item(100000, 200000, -300000, -7, 3, 0, -1200000000));
        list.push_back(make_item(-65536, 65536, 65536, 0, 1, 0, 1686629712));
        foreach (list[i]) drive_item(list[i], (i % 3 == 0) ? 0 : $urandom_range(0, 3));

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 2) begin
                start <= 1'b0;
                while (board.pending.size() != 0) @(posedge clk);
                drive_item(random_item(), 1);
            end
            else if ((n / 40) % 3 == 1) drive_item(random_item(), 0);
            else drive_item(random_item(), $urandom_range(0, 10));
        end
        start <= 1'b0;

        while (board.pending.size() != 0) @(posedge clk);
        settle = rvr_pkg::PIPE_LAT + 20;
        repeat (settle) @(posedge clk);
        if (board.errors == 0)
            $display("rodrigues_vector_rotation_test: PASS");
        else
            $display("rodrigues_vector_rotation_test: FAIL");
        $finish;
    end

endmodule
